### rtl/afst_pkg.sv
// ----------------------------------------------------------------------------
// afst_pkg: shared types and constants of the frame sequence timestamper
// Payload structs, configuration register indexes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package afst_pkg;

  // Block dimensions
  localparam int GROUP_COUNT   = 3;
  localparam int MAX_SEQUENCES = 64;
  localparam int SEQ_CNT_W     = 7;   // holds 1..MAX_SEQUENCES
  localparam int SEQ_IDX_W     = 6;
  localparam int COUNT_W       = 10;
  localparam int RANKS_W       = 5;
  localparam int TS_W          = 32;
  localparam int DIV_STEP_W    = 5;

  // Input opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_EST_FIRST_PAIR = 3'd0;
  localparam logic [2:0] CFG_EST_THIRD      = 3'd1;
  localparam logic [2:0] CFG_RANKS_ZERO     = 3'd2;
  localparam logic [2:0] CFG_RANKS_ONE      = 3'd3;
  localparam logic [2:0] CFG_RANKS_TWO      = 3'd4;

  // Group codes
  localparam logic [1:0] GRP_ZERO = 2'd0;
  localparam logic [1:0] GRP_ONE  = 2'd1;
  localparam logic [1:0] GRP_TWO  = 2'd2;

  typedef struct packed {
    logic                 opcode;
    logic [1:0]           group;
    logic [COUNT_W-1:0]   sample_count;
    logic [TS_W-1:0]      frame_timestamp;
  } afst_in_t;

  typedef struct packed {
    logic [1:0]           out_group;
    logic [SEQ_IDX_W-1:0] sequence_index;
    logic [COUNT_W-1:0]   element_offset;
    logic [TS_W-1:0]      sequence_timestamp;
    logic [TS_W-1:0]      interval_ticks;
    logic                 count_clipped;
    logic                 last;
  } afst_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted descriptor
    logic clear_hist;   // drop all histories
    logic div_cnt;      // start sample count / ranks
    logic div_int;      // start delta / sequence count
    logic div_step;     // one divider iteration
    logic take_total;   // latch sequence count
    logic take_est;     // interval from the configured estimate
    logic take_quo;     // interval from the divider
    logic upd_hist;     // store frame timestamp as history
    logic prep;         // product and first offset
    logic ts_init;      // first sequence timestamp
    logic emit;         // load one result into the output register
  } afst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_clear;     // input descriptor is a clear request
    logic in_known;     // input group is a known group
    logic div_last;     // divider is on its final iteration
    logic total_zero;   // no sequences in the frame
    logic hist_ok;      // history present and sequences non-zero
    logic last_seq;     // current sequence is the final one
    logic out_free;     // output register can take a result
  } afst_sts_t;

endpackage

`default_nettype wire

### rtl/afst_ctrl.sv
// ----------------------------------------------------------------------------
// afst_ctrl: sequencing controller of the frame sequence timestamper
// Steps each known-group frame through the count division, the interval
// division given history, the first timestamp and one result per sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_ctrl import afst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire afst_sts_t sts,
  output afst_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DCNT = 3'd2;
  localparam logic [2:0] ST_TOT  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DINT = 3'd5;
  localparam logic [2:0] ST_MUL  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       ts_pend_r;
  logic       ts_pend_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    ts_pend_nxt = ts_pend_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_clear) begin
            cmd.clear_hist = 1'b1;
          end else if (sts.in_known) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_cnt = 1'b1;
        state_nxt   = ST_DCNT;
      end
      ST_DCNT: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TOT;
        end
      end
      ST_TOT: begin
        cmd.take_total = 1'b1;
        state_nxt      = ST_CHK;
      end
      ST_CHK: begin
        if (sts.hist_ok) begin
          cmd.div_int = 1'b1;
          state_nxt   = ST_DINT;
        end else begin
          cmd.take_est = 1'b1;
          cmd.upd_hist = 1'b1;
          state_nxt    = sts.total_zero ? ST_IDLE : ST_MUL;
        end
      end
      ST_DINT: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          // quotient is complete after this step; latch it in ST_MUL's way
          state_nxt   = ST_MUL;
          ts_pend_nxt = 1'b1;
        end
      end
      ST_MUL: begin
        if (ts_pend_r) begin
          // take the finished quotient first, then compute the product
          cmd.take_quo = 1'b1;
          cmd.upd_hist = 1'b1;
          ts_pend_nxt  = 1'b0;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_EMIT;
          ts_pend_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (ts_pend_r) begin
          cmd.ts_init = 1'b1;
          ts_pend_nxt = 1'b0;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_seq) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        ts_pend_nxt = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ts_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ts_pend_r <= ts_pend_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/afst_dpath.sv
// ----------------------------------------------------------------------------
// afst_dpath: datapath of the frame sequence timestamper
// Configuration registers, per-group history, a shared restoring divider,
// the first-timestamp multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afst_dpath import afst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire afst_in_t   in_data,
  input  wire logic       cfg_valid,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output afst_out_t       out_data,
  input  wire afst_cmd_t  cmd,
  output afst_sts_t       sts
);

  // Configuration
  logic [TS_W-1:0]    est_pair_r;
  logic [TS_W-1:0]    est_third_r;
  logic [RANKS_W-1:0] ranks0_r;
  logic [RANKS_W-1:0] ranks1_r;
  logic [RANKS_W-1:0] ranks2_r;

  // History
  logic            hist_valid_r [GROUP_COUNT];
  logic [TS_W-1:0] prev_time_r  [GROUP_COUNT];

  // Captured descriptor and frame values
  logic [1:0]           grp_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic [TS_W-1:0]      stamp_r;
  logic [COUNT_W-1:0]   total_r;
  logic [TS_W-1:0]      interval_r;
  logic [SEQ_CNT_W-1:0] n_r;
  logic                 clipped_r;
  logic [TS_W-1:0]      prod_r;
  logic [TS_W-1:0]      ts_r;
  logic [COUNT_W-1:0]   offset_r;
  logic [SEQ_IDX_W-1:0] k_r;

  // Divider
  logic [COUNT_W-1:0]    div_rem_r;
  logic [TS_W-1:0]       div_quo_r;
  logic [COUNT_W-1:0]    div_dsr_r;
  logic [DIV_STEP_W-1:0] div_cnt_r;
  logic [COUNT_W:0]      div_shift;
  logic                  div_ge;
  logic [COUNT_W:0]      div_diff;

  // Output
  logic      out_valid_r;
  afst_out_t out_r;

  // Frame selections
  logic [RANKS_W-1:0]   ranks_sel;
  logic [TS_W-1:0]      est_sel;
  logic                 clip_now;
  logic [SEQ_CNT_W-1:0] n_now;
  logic [COUNT_W-1:0]   skip_now;
  logic [SEQ_IDX_W-1:0] n_less1;
  logic [TS_W+SEQ_IDX_W-1:0] prod_full;
  logic [COUNT_W+RANKS_W-1:0] skip_off;
  logic [SEQ_IDX_W-1:0] last_k;

  always_comb begin
    case (grp_r)
      GRP_ZERO: begin
        ranks_sel = ranks0_r;
        est_sel   = est_pair_r;
      end
      GRP_ONE: begin
        ranks_sel = ranks1_r;
        est_sel   = est_pair_r;
      end
      GRP_TWO: begin
        ranks_sel = ranks2_r;
        est_sel   = est_third_r;
      end
      default: begin
        ranks_sel = '0;
        est_sel   = '0;
      end
    endcase
  end

  // Sequence count saturation
  assign clip_now  = (total_r > COUNT_W'(MAX_SEQUENCES));
  assign n_now     = clip_now ? SEQ_CNT_W'(MAX_SEQUENCES) : total_r[SEQ_CNT_W-1:0];
  assign skip_now  = total_r - COUNT_W'(n_now);
  assign n_less1   = SEQ_IDX_W'(n_now - SEQ_CNT_W'(1));
  assign prod_full = n_less1 * interval_r;
  assign skip_off  = skip_now * ranks_sel;
  assign last_k    = SEQ_IDX_W'(n_r - SEQ_CNT_W'(1));

  // Restoring divider step
  assign div_shift = {div_rem_r, div_quo_r[TS_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_dsr_r});
  assign div_diff  = div_shift - {1'b0, div_dsr_r};

  // Status
  assign sts.in_clear   = (in_data.opcode == OP_CLEAR);
  assign sts.in_known   = (in_data.group < 2'(GROUP_COUNT));
  assign sts.div_last   = (div_cnt_r == '0);
  assign sts.total_zero = (total_r == '0);
  assign sts.hist_ok    = hist_valid_r[grp_r] && (total_r != '0);
  assign sts.last_seq   = (k_r == last_k);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_pair_r  <= '0;
      est_third_r <= '0;
      ranks0_r    <= RANKS_W'(1);
      ranks1_r    <= RANKS_W'(1);
      ranks2_r    <= RANKS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EST_FIRST_PAIR: est_pair_r  <= cfg_data;
        CFG_EST_THIRD:      est_third_r <= cfg_data;
        CFG_RANKS_ZERO:     ranks0_r    <= cfg_data[RANKS_W-1:0];
        CFG_RANKS_ONE:      ranks1_r    <= cfg_data[RANKS_W-1:0];
        CFG_RANKS_TWO:      ranks2_r    <= cfg_data[RANKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Per-group history
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_hist) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        hist_valid_r[g] <= 1'b0;
        prev_time_r[g]  <= '0;
      end
    end else if (cmd.upd_hist) begin
      hist_valid_r[grp_r] <= 1'b1;
      prev_time_r[grp_r]  <= stamp_r;
    end
  end

  // Divider: count / ranks uses ten steps, delta / count uses thirty-two
  always_ff @(posedge clk) begin
    if (cmd.div_cnt) begin
      div_rem_r <= '0;
      div_quo_r <= {cnt_r, (TS_W-COUNT_W)'(0)};
      div_dsr_r <= COUNT_W'(ranks_sel);
      div_cnt_r <= DIV_STEP_W'(COUNT_W - 1);
    end else if (cmd.div_int) begin
      div_rem_r <= '0;
      div_quo_r <= stamp_r - prev_time_r[grp_r];
      div_dsr_r <= total_r;
      div_cnt_r <= DIV_STEP_W'(TS_W - 1);
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
      div_quo_r <= {div_quo_r[TS_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - DIV_STEP_W'(1);
    end
  end

  // Frame registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      grp_r   <= in_data.group;
      cnt_r   <= in_data.sample_count;
      stamp_r <= in_data.frame_timestamp;
    end
    if (cmd.take_total) begin
      // a zero ranks register gives no sequences
      total_r <= (ranks_sel == '0) ? '0 : div_quo_r[COUNT_W-1:0];
    end
    if (cmd.take_est) begin
      interval_r <= est_sel;
    end else if (cmd.take_quo) begin
      interval_r <= div_quo_r;
    end
    if (cmd.prep) begin
      prod_r    <= prod_full[TS_W-1:0];
      offset_r  <= skip_off[COUNT_W-1:0];
      n_r       <= n_now;
      clipped_r <= clip_now;
    end
    if (cmd.ts_init) begin
      ts_r <= stamp_r - prod_r;
      k_r  <= '0;
    end else if (cmd.emit) begin
      ts_r     <= ts_r + interval_r;
      offset_r <= offset_r + COUNT_W'(ranks_sel);
      k_r      <= k_r + SEQ_IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_group          <= grp_r;
      out_r.sequence_index     <= k_r;
      out_r.element_offset     <= offset_r;
      out_r.sequence_timestamp <= ts_r;
      out_r.interval_ticks     <= interval_r;
      out_r.count_clipped      <= clipped_r;
      out_r.last               <= (k_r == last_k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/adc_frame_sequence_timestamper.sv
// ----------------------------------------------------------------------------
// adc_frame_sequence_timestamper: per-sequence timestamps for DMA half buffers
// Input descriptors arrive on in_valid/in_ready with payload in_data. Each
// frame request of a known group yields one result per sequence on
// out_valid/out_ready (payload out_data), at most MAX_SEQUENCES of them; clear requests and unknown groups
// yield none. Registers are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user writes them only while idle, which the block does not enforce; cfg_ready is always high.
// Timing: a frame request takes a ten-step count division, a thirty-two-step
// interval division (skipped when the group has no history or the frame has
// no sequences), the set-up of the product and first timestamp and then one
// result per cycle while the receiver takes them. The shared divider yields
// one quotient bit per cycle. Clear requests and unknown groups are consumed
// in the idle state. in_ready is high only while the controller is idle.
// Reset: synchronous, clears all histories and sets the registers to their
// defaults. A stalled receiver holds the output register, and emission waits
// until it is taken; the final result may still be waiting when the next
// request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_frame_sequence_timestamper import afst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire afst_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output afst_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  afst_cmd_t cmd;
  afst_sts_t sts;

  assign cfg_ready = 1'b1;

  afst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afst_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### tb/sv/afst_sequence_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afst_sequence_checker: prediction and comparison for the timestamper
// Watches the configuration, descriptor and result channels. Every accepted
// descriptor is run through a local model of the per-group history and the
// interpolation, and the sequence results it implies are queued in order.
// Each accepted result is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------

module afst_sequence_checker import afst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  afst_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  afst_out_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output int unsigned      mismatch_count,
  output int unsigned      seqs_pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Local copy of the registers and of the per-group history
  logic [TS_W-1:0]    est_first_pair;
  logic [TS_W-1:0]    est_third;
  logic [RANKS_W-1:0] ranks         [GROUP_COUNT];
  logic               history_seen  [GROUP_COUNT];
  logic [TS_W-1:0]    last_end_time [GROUP_COUNT];

  afst_out_t   expected_seqs [$];
  int unsigned fails = 0;

  // Work out the sequence results of one descriptor and update the history
  function automatic void predict_frame(input afst_in_t req);
    int unsigned        gi;
    int unsigned        total;
    int unsigned        n;
    int unsigned        skip;
    logic [RANKS_W-1:0] rk;
    logic [TS_W-1:0]    interval;
    logic [TS_W-1:0]    delta;
    logic [TS_W-1:0]    ts;
    logic               clipped;
    afst_out_t          seq;
    if (req.opcode == OP_CLEAR) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        history_seen[g]  = 1'b0;
        last_end_time[g] = '0;
      end
      return;
    end
    if (req.group >= GROUP_COUNT) return;

    gi       = req.group;
    rk       = ranks[gi];
    interval = (req.group == GRP_TWO) ? est_third : est_first_pair;
    total    = (rk == 0) ? 0 : req.sample_count / rk;

    // First frame of a group, or one with no sequences, falls back to the estimate
    if (history_seen[gi] && total != 0) begin
      delta    = req.frame_timestamp - last_end_time[gi];
      interval = delta / total;
    end
    last_end_time[gi] = req.frame_timestamp;
    history_seen[gi]  = 1'b1;
    if (total == 0) return;

    // Saturation keeps only the final sequences, still ending on the stamp
    clipped = (total > MAX_SEQUENCES);
    n       = clipped ? MAX_SEQUENCES : total;
    skip    = total - n;
    ts      = req.frame_timestamp - TS_W'(32'(n - 1) * interval);
    for (int unsigned k = 0; k < n; k++) begin
      seq.out_group          = req.group;
      seq.sequence_index     = SEQ_IDX_W'(k);
      seq.element_offset     = COUNT_W'((skip + k) * rk);
      seq.sequence_timestamp = ts;
      seq.interval_ticks     = interval;
      seq.count_clipped      = clipped;
      seq.last               = (k == n - 1);
      expected_seqs.push_back(seq);
      ts = ts + interval;
    end
  endfunction

  always @(posedge clk) begin : monitor
    afst_out_t want;
    if (!rst_n) begin
      est_first_pair = '0;
      est_third      = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        ranks[g]         = RANKS_W'(1);
        history_seen[g]  = 1'b0;
        last_end_time[g] = '0;
      end
      expected_seqs.delete();
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EST_FIRST_PAIR: est_first_pair = cfg_data;
          CFG_EST_THIRD:      est_third      = cfg_data;
          CFG_RANKS_ZERO:     ranks[0]       = cfg_data[RANKS_W-1:0];
          CFG_RANKS_ONE:      ranks[1]       = cfg_data[RANKS_W-1:0];
          CFG_RANKS_TWO:      ranks[2]       = cfg_data[RANKS_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) predict_frame(in_data);

      // Result comparison against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_seqs.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("[%0t] result with nothing expected: grp=%0d idx=%0d off=%0d ts=%h",
                     $time, out_data.out_group, out_data.sequence_index,
                     out_data.element_offset, out_data.sequence_timestamp);
        end else begin
          want = expected_seqs.pop_front();
          if (out_data.out_group          !== want.out_group          ||
              out_data.sequence_index     !== want.sequence_index     ||
              out_data.element_offset     !== want.element_offset     ||
              out_data.sequence_timestamp !== want.sequence_timestamp ||
              out_data.interval_ticks     !== want.interval_ticks     ||
              out_data.count_clipped      !== want.count_clipped      ||
              out_data.last               !== want.last) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display({"[%0t] sequence mismatch, exp: grp=%0d idx=%0d off=%0d",
                        " ts=%h int=%h clip=%0b last=%0b"},
                       $time, want.out_group, want.sequence_index, want.element_offset,
                       want.sequence_timestamp, want.interval_ticks, want.count_clipped,
                       want.last);
              $display("           got: grp=%0d idx=%0d off=%0d ts=%h int=%h clip=%0b last=%0b",
                       out_data.out_group, out_data.sequence_index, out_data.element_offset,
                       out_data.sequence_timestamp, out_data.interval_ticks,
                       out_data.count_clipped, out_data.last);
            end
          end
        end
      end
    end
    mismatch_count <= fails;
    seqs_pending   <= expected_seqs.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for adc_frame_sequence_timestamper
// Drives frame, clear and unknown-group requests under several register
// settings, with random idle bursts on both channels. Prediction and
// comparison live in afst_sequence_checker; this module only makes the
// traffic, keeps the watchdog and reports the outcome.
// ----------------------------------------------------------------------------

module tb import afst_pkg::*;;

  localparam logic [1:0]  GRP_UNKNOWN      = 2'd3;
  localparam int unsigned SETTLE_CYCLES    = 120;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned REQS_PER_PHASE   = 60;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  afst_in_t    in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  afst_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        cfg_ready;

  int unsigned mismatch_count;
  int unsigned seqs_pending;
  int unsigned idle_pct   = 0;
  int unsigned stall_left = 0;
  logic [TS_W-1:0] group_time [GROUP_COUNT] = '{default: '0};

  adc_frame_sequence_timestamper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afst_sequence_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .seqs_pending   (seqs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Watchdog: too long without any request moving ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic afst_in_t make_req(input logic op, input logic [1:0] grp,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [TS_W-1:0] stamp);
    afst_in_t req;
    req.opcode          = op;
    req.group           = grp;
    req.sample_count    = cnt;
    req.frame_timestamp = stamp;
    return req;
  endfunction

  // Present one request; valid stays high unless an idle burst lowers it
  task automatic send_req(input afst_in_t req);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [31:0] est_pair, input logic [31:0] est_third,
                              input logic [4:0] r0, input logic [4:0] r1,
                              input logic [4:0] r2);
    write_reg(CFG_EST_FIRST_PAIR, est_pair);
    write_reg(CFG_EST_THIRD, est_third);
    write_reg(CFG_RANKS_ZERO, {27'd0, r0});
    write_reg(CFG_RANKS_ONE, {27'd0, r1});
    write_reg(CFG_RANKS_TWO, {27'd0, r2});
    cfg_valid <= 1'b0;
  endtask

  // Let every expected result arrive, then allow for a silent request
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (seqs_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_ranks();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return 5'($urandom_range(1, 16));
    if (p < 80) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic logic [31:0] pick_estimate();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 2) return 32'd0;
    if (p < 4) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Mostly short buffers, some anywhere, a few near the top
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 6) return COUNT_W'($urandom_range(0, 150));
    if (p < 8) return COUNT_W'($urandom);
    return COUNT_W'($urandom_range(960, 1023));
  endfunction

  // Mostly in-order frames per group; some clears, unknown groups and jumps
  task automatic send_random_req();
    int unsigned      p;
    int unsigned      gi;
    logic [TS_W-1:0]  stamp;
    p = $urandom_range(0, 99);
    if (p < 4) begin
      send_req(make_req(OP_CLEAR, 2'($urandom), COUNT_W'($urandom), $urandom));
    end else if (p < 8) begin
      send_req(make_req(OP_FRAME, GRP_UNKNOWN, COUNT_W'($urandom), $urandom));
    end else begin
      gi = $urandom_range(0, GROUP_COUNT - 1);
      if (p < 85)
        stamp = group_time[gi] + $urandom_range(0, 200000);
      else
        stamp = $urandom;
      group_time[gi] = stamp;
      send_req(make_req(OP_FRAME, 2'(gi), pick_count(), stamp));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n    <= 1'b1;
    idle_pct = 25;

    // Reset defaults: estimate zero, one rank per sequence
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd0, 32'd1000));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd5, 32'd1038));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd5, 32'd20));
    send_req(make_req(OP_FRAME, GRP_ONE, 10'd1023, 32'hFFFF_FFFF));
    send_req(make_req(OP_FRAME, GRP_TWO, 10'd1, 32'd0));
    send_req(make_req(OP_FRAME, GRP_UNKNOWN, 10'd1023, 32'hFFFF_FFFF));
    send_req(make_req(OP_CLEAR, GRP_UNKNOWN, 10'd1023, 32'hFFFF_FFFF));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd3, 32'd500));
    wait_idle();

    // Largest estimate, sixteen ranks, zero ranks, ranks above sixteen
    program_regs(32'hFFFF_FFFF, 32'h0001_2345, 5'd16, 5'd0, 5'd31);
    send_req(make_req(OP_CLEAR, GRP_ZERO, 10'd0, 32'd0));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd1023, 32'h8000_0000));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd15, 32'h9000_0000));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd16, 32'h9000_0010));
    send_req(make_req(OP_FRAME, GRP_ONE, 10'd100, 32'd123));
    send_req(make_req(OP_FRAME, GRP_ONE, 10'd200, 32'd50));
    send_req(make_req(OP_FRAME, GRP_TWO, 10'd1023, 32'hFFFF_FFF0));
    send_req(make_req(OP_FRAME, GRP_TWO, 10'd1023, 32'h0000_0100));
    send_req(make_req(OP_FRAME, GRP_TWO, 10'd30, 32'd7));
    wait_idle();

    // One rank: saturation with history, and the exact limit either side
    program_regs(32'd0, 32'hFFFF_FFFF, 5'd1, 5'd1, 5'd1);
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd1023, 32'd0));
    send_req(make_req(OP_FRAME, GRP_ZERO, 10'd1023, 32'hFFFF_FFFF));
    send_req(make_req(OP_FRAME, GRP_ONE, 10'd64, 32'd64000));
    send_req(make_req(OP_FRAME, GRP_ONE, 10'd65, 32'd70000));
    send_req(make_req(OP_CLEAR, GRP_TWO, 10'd0, 32'd0));
    send_req(make_req(OP_FRAME, GRP_TWO, 10'd64, 32'h0000_1000));

    // Random phases, each under fresh register values; no idling at the end
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      program_regs(pick_estimate(), pick_estimate(), pick_ranks(), pick_ranks(),
                   pick_ranks());
      idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 40);
      repeat (REQS_PER_PHASE) send_random_req();
    end
    wait_idle();

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
